@@ sv/tars_pkg.sv @@
package tars_pkg;

    // Storage shape
    localparam int MAX_PARTIALS = 1024;
    localparam int ADDR_W       = (MAX_PARTIALS > 1) ? $clog2(MAX_PARTIALS) : 1;

    // Field widths
    localparam int DIM_MAX  = 4096;
    localparam int DIM_W    = 13;
    localparam int CNT_W    = 12;
    localparam int AXIS_W   = 2;
    localparam int ELEM_W   = 32;
    localparam int ACC_W    = 48;
    localparam int POS_W    = 24;
    localparam int CFG_IDX_W = 2;

    localparam logic [ELEM_W-1:0] SUM_MAX = {1'b0, {(ELEM_W-1){1'b1}}};
    localparam logic [ELEM_W-1:0] SUM_MIN = {1'b1, {(ELEM_W-1){1'b0}}};

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SIZE_OUTER  = 2'd0,
        REG_SIZE_MIDDLE = 2'd1,
        REG_SIZE_INNER  = 2'd2,
        REG_REDUCE_AXIS = 2'd3
    } cfg_index_t;

    // Reduced axis codes
    localparam logic [AXIS_W-1:0] AXIS_OUTER  = 2'd0;
    localparam logic [AXIS_W-1:0] AXIS_MIDDLE = 2'd1;
    localparam logic [AXIS_W-1:0] AXIS_INNER  = 2'd2;

    // Effective tensor shape, already clamped
    typedef struct packed {
        logic [DIM_W-1:0]  size_outer;
        logic [DIM_W-1:0]  size_middle;
        logic [DIM_W-1:0]  size_inner;
        logic [AXIS_W-1:0] axis;
    } shape_t;

    // Per-item control from the address generator
    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic              first;
        logic              emit;
        logic              last;
        logic [POS_W-1:0]  position;
    } item_ctl_t;

    function automatic logic [DIM_W-1:0] eff_size(input logic [DIM_W-1:0] s);
        logic [DIM_W-1:0] r;
        if (s == '0) begin
            r = DIM_W'(1);
        end else if (s > DIM_W'(DIM_MAX)) begin
            r = DIM_W'(DIM_MAX);
        end else begin
            r = s;
        end
        return r;
    endfunction

    function automatic logic [AXIS_W-1:0] eff_axis(input logic [AXIS_W-1:0] a);
        logic [AXIS_W-1:0] r;
        if (a > AXIS_INNER) begin
            r = AXIS_INNER;
        end else begin
            r = a;
        end
        return r;
    endfunction

endpackage

@@ sv/tars_psum_ram.sv @@
module tars_psum_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 48
) (
    input  logic                                   aclk,
    input  logic                                   wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read-before-write on a shared address
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ sv/tars_addr_gen.sv @@
module tars_addr_gen (
    input  logic                aclk,
    input  logic                aresetn,
    input  tars_pkg::shape_t    shape,
    input  logic                clear,
    input  logic                advance,
    output tars_pkg::item_ctl_t ctl
);

    logic [tars_pkg::CNT_W-1:0]  cnt_outer_reg, cnt_outer_next;
    logic [tars_pkg::CNT_W-1:0]  cnt_middle_reg, cnt_middle_next;
    logic [tars_pkg::CNT_W-1:0]  cnt_inner_reg, cnt_inner_next;
    logic [tars_pkg::ADDR_W-1:0] addr_reg, addr_next;
    logic [tars_pkg::ADDR_W-1:0] base_reg, base_next;
    logic [tars_pkg::POS_W-1:0]  pos_reg, pos_next;

    logic                        end_outer, end_middle, end_inner, last;
    logic [tars_pkg::ADDR_W-1:0] addr_inc;

    assign end_outer  = (tars_pkg::DIM_W'({1'b0, cnt_outer_reg}) + tars_pkg::DIM_W'(1))
                        == shape.size_outer;
    assign end_middle = (tars_pkg::DIM_W'({1'b0, cnt_middle_reg}) + tars_pkg::DIM_W'(1))
                        == shape.size_middle;
    assign end_inner  = (tars_pkg::DIM_W'({1'b0, cnt_inner_reg}) + tars_pkg::DIM_W'(1))
                        == shape.size_inner;
    assign last       = end_outer && end_middle && end_inner;

    assign addr_inc = (addr_reg == tars_pkg::ADDR_W'(tars_pkg::MAX_PARTIALS - 1))
                      ? '0 : addr_reg + tars_pkg::ADDR_W'(1);

    always_comb begin
        ctl.addr     = addr_reg;
        ctl.last     = last;
        ctl.position = pos_reg;
        case (shape.axis)
            tars_pkg::AXIS_OUTER: begin
                ctl.first = (cnt_outer_reg == '0);
                ctl.emit  = end_outer;
            end
            tars_pkg::AXIS_MIDDLE: begin
                ctl.first = (cnt_middle_reg == '0);
                ctl.emit  = end_middle;
            end
            default: begin
                ctl.first = (cnt_inner_reg == '0);
                ctl.emit  = end_inner;
            end
        endcase
    end

    // Step the coordinates and the partial-sum address in row-major order
    always_comb begin
        cnt_outer_next  = cnt_outer_reg;
        cnt_middle_next = cnt_middle_reg;
        cnt_inner_next  = cnt_inner_reg;
        addr_next       = addr_reg;
        base_next       = base_reg;
        pos_next        = pos_reg;
        if (last) begin
            cnt_outer_next  = '0;
            cnt_middle_next = '0;
            cnt_inner_next  = '0;
            addr_next       = '0;
            base_next       = '0;
            pos_next        = '0;
        end else begin
            if (ctl.emit) begin
                pos_next = pos_reg + tars_pkg::POS_W'(1);
            end
            if (!end_inner) begin
                cnt_inner_next = cnt_inner_reg + tars_pkg::CNT_W'(1);
            end else begin
                cnt_inner_next = '0;
                if (!end_middle) begin
                    cnt_middle_next = cnt_middle_reg + tars_pkg::CNT_W'(1);
                end else begin
                    cnt_middle_next = '0;
                    cnt_outer_next  = cnt_outer_reg + tars_pkg::CNT_W'(1);
                end
            end
            case (shape.axis)
                tars_pkg::AXIS_OUTER: begin
                    // Output index is middle*inner + inner: restart per outer slice
                    addr_next = (end_inner && end_middle) ? '0 : addr_inc;
                end
                tars_pkg::AXIS_MIDDLE: begin
                    // Output index is outer*inner + inner: rewind per middle row
                    if (end_inner && !end_middle) begin
                        addr_next = base_reg;
                    end else if (end_inner) begin
                        addr_next = addr_inc;
                        base_next = addr_inc;
                    end else begin
                        addr_next = addr_inc;
                    end
                end
                default: begin
                    // Output index is outer*middle + middle: hold across inner
                    addr_next = end_inner ? addr_inc : addr_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            cnt_outer_reg  <= '0;
            cnt_middle_reg <= '0;
            cnt_inner_reg  <= '0;
            addr_reg       <= '0;
            base_reg       <= '0;
            pos_reg        <= '0;
        end else if (advance) begin
            cnt_outer_reg  <= cnt_outer_next;
            cnt_middle_reg <= cnt_middle_next;
            cnt_inner_reg  <= cnt_inner_next;
            addr_reg       <= addr_next;
            base_reg       <= base_next;
            pos_reg        <= pos_next;
        end
    end

endmodule

@@ sv/tensor_axis_reduce_sum.sv @@
// Reduce-sum of a streamed 3-D tensor along one configured axis.
// An accepted item is registered into stage 1, and any sum it finishes into the output register on m_.
// Throughput: one item per cycle unless a sum waits on a full output register;
// the partial-sum memory reads and writes at once; back-to-back hits are forwarded.
// Reset (aresetn low, synchronous) clears the coordinates, output index and
// pipeline valids, and sets the shape to 1x1x1 with axis 0; no memory sweep.
module tensor_axis_reduce_sum (
    input  logic                              aclk,
    input  logic                              aresetn,

    // Configuration write port
    input  logic                              cfg_wr_en,
    input  logic [tars_pkg::CFG_IDX_W-1:0]    cfg_wr_index,
    input  logic [tars_pkg::DIM_W-1:0]        cfg_wr_data,

    // Element stream
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [tars_pkg::ELEM_W-1:0] s_element_value,

    // Sum stream
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [tars_pkg::ELEM_W-1:0] m_sum_value,
    output logic [tars_pkg::POS_W-1:0]        m_out_position,
    output logic                              m_tensor_done
);

    // ------------------------------------------------------------------
    // Configuration registers; any write starts a new tensor
    // ------------------------------------------------------------------
    logic [tars_pkg::DIM_W-1:0]  size_outer_reg;
    logic [tars_pkg::DIM_W-1:0]  size_middle_reg;
    logic [tars_pkg::DIM_W-1:0]  size_inner_reg;
    logic [tars_pkg::AXIS_W-1:0] reduce_axis_reg;
    tars_pkg::shape_t            shape;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_outer_reg  <= tars_pkg::DIM_W'(1);
            size_middle_reg <= tars_pkg::DIM_W'(1);
            size_inner_reg  <= tars_pkg::DIM_W'(1);
            reduce_axis_reg <= tars_pkg::AXIS_OUTER;
        end else if (cfg_wr_en) begin
            case (tars_pkg::cfg_index_t'(cfg_wr_index))
                tars_pkg::REG_SIZE_OUTER:  size_outer_reg  <= cfg_wr_data;
                tars_pkg::REG_SIZE_MIDDLE: size_middle_reg <= cfg_wr_data;
                tars_pkg::REG_SIZE_INNER:  size_inner_reg  <= cfg_wr_data;
                tars_pkg::REG_REDUCE_AXIS:
                    reduce_axis_reg <= cfg_wr_data[tars_pkg::AXIS_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp zero sizes to one, oversize to the max, axis three to inner
    assign shape.size_outer  = tars_pkg::eff_size(size_outer_reg);
    assign shape.size_middle = tars_pkg::eff_size(size_middle_reg);
    assign shape.size_inner  = tars_pkg::eff_size(size_inner_reg);
    assign shape.axis        = tars_pkg::eff_axis(reduce_axis_reg);

    // ------------------------------------------------------------------
    // Pipeline control
    //   stage 0: accept item, issue partial-sum read
    //   stage 1: add, write back, saturate into output register
    // ------------------------------------------------------------------
    logic                      accept;
    logic                      s1_adv;
    logic                      s1_valid_reg;
    tars_pkg::item_ctl_t       s1_ctl_reg;
    logic [tars_pkg::ELEM_W-1:0] s1_elem_reg;
    logic                      fwd_hit_reg;
    logic [tars_pkg::ACC_W-1:0] fwd_data_reg;
    tars_pkg::item_ctl_t       ctl;

    logic [tars_pkg::ACC_W-1:0] rd_data;
    logic [tars_pkg::ACC_W-1:0] elem_ext;
    logic [tars_pkg::ACC_W-1:0] acc_base;
    logic [tars_pkg::ACC_W-1:0] acc;
    logic [tars_pkg::ELEM_W-1:0] sum_sat;
    logic                       fits;

    logic                        out_valid_reg;
    logic [tars_pkg::ELEM_W-1:0] out_sum_reg;
    logic [tars_pkg::POS_W-1:0]  out_pos_reg;
    logic                        out_done_reg;

    // Stage 1 moves on unless it holds a sum and the output register is full
    assign s1_adv  = s1_valid_reg && (!s1_ctl_reg.emit || !out_valid_reg || m_ready);
    assign s_ready = !s1_valid_reg || s1_adv;
    assign accept  = s_valid && s_ready;

    tars_addr_gen u_addr_gen (
        .aclk    (aclk),
        .aresetn (aresetn),
        .shape   (shape),
        .clear   (cfg_wr_en),
        .advance (accept),
        .ctl     (ctl)
    );

    tars_psum_ram #(
        .DEPTH (tars_pkg::MAX_PARTIALS),
        .WIDTH (tars_pkg::ACC_W)
    ) u_psum_ram (
        .aclk    (aclk),
        .wr_en   (s1_adv),
        .wr_addr (s1_ctl_reg.addr),
        .wr_data (acc),
        .rd_en   (accept),
        .rd_addr (ctl.addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (accept) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_adv) begin
            s1_valid_reg <= 1'b0;
        end
    end

    // The memory read misses a write-back on the same edge: forward it
    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_ctl_reg   <= ctl;
            s1_elem_reg  <= s_element_value;
            fwd_hit_reg  <= s1_adv && (s1_ctl_reg.addr == ctl.addr);
            fwd_data_reg <= acc;
        end
    end

    // ------------------------------------------------------------------
    // Accumulate: first slice overwrites, later slices add (48-bit wrap)
    // ------------------------------------------------------------------
    assign elem_ext = {{(tars_pkg::ACC_W - tars_pkg::ELEM_W){s1_elem_reg[tars_pkg::ELEM_W-1]}},
                       s1_elem_reg};
    assign acc_base = fwd_hit_reg ? fwd_data_reg : rd_data;
    assign acc      = s1_ctl_reg.first ? elem_ext : acc_base + elem_ext;

    // Saturate to 32 bits: fits when all bits above bit 31 match the sign
    assign fits    = (acc[tars_pkg::ACC_W-1:tars_pkg::ELEM_W-1] == '0) ||
                     (acc[tars_pkg::ACC_W-1:tars_pkg::ELEM_W-1] == '1);
    assign sum_sat = fits ? acc[tars_pkg::ELEM_W-1:0]
                   : (acc[tars_pkg::ACC_W-1] ? tars_pkg::SUM_MIN : tars_pkg::SUM_MAX);

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (s1_adv && s1_ctl_reg.emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv && s1_ctl_reg.emit) begin
            out_sum_reg  <= sum_sat;
            out_pos_reg  <= s1_ctl_reg.position;
            out_done_reg <= s1_ctl_reg.last;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_sum_value    = out_sum_reg;
    assign m_out_position = out_pos_reg;
    assign m_tensor_done  = out_done_reg;

endmodule

@@ verif/reduce_sum_checker.sv @@
module reduce_sum_checker (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [tars_pkg::CFG_IDX_W-1:0]     cfg_wr_index,
    input  logic [tars_pkg::DIM_W-1:0]         cfg_wr_data,
    input  logic                               s_valid,
    input  logic                               s_ready,
    input  logic signed [tars_pkg::ELEM_W-1:0] s_element_value,
    input  logic                               m_valid,
    input  logic                               m_ready,
    input  logic signed [tars_pkg::ELEM_W-1:0] m_sum_value,
    input  logic [tars_pkg::POS_W-1:0]         m_out_position,
    input  logic                               m_tensor_done,
    output int                                 failures,
    output int                                 pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import tars_pkg::*;

    localparam logic signed [ACC_W-1:0] ACC_SAT_HI = $signed(SUM_MAX);
    localparam logic signed [ACC_W-1:0] ACC_SAT_LO = $signed(SUM_MIN);

    typedef struct {
        logic signed [ELEM_W-1:0] sum;
        logic [POS_W-1:0]         position;
        logic                     done;
    } sum_rec_t;

    sum_rec_t sums_due[$];

    // Shadow of the block: shape registers, coordinates and partial-sum store
    logic signed [ACC_W-1:0] part_mem [MAX_PARTIALS];
    logic [DIM_W-1:0]        reg_outer, reg_middle, reg_inner;
    logic [AXIS_W-1:0]       reg_axis;
    int unsigned             at_outer, at_middle, at_inner;
    logic [POS_W-1:0]        next_pos;

    function automatic int unsigned dim_of(input logic [DIM_W-1:0] s);
        int unsigned r;
        r = s;
        if (r == 0) begin
            r = 1;
        end else if (r > DIM_MAX) begin
            r = DIM_MAX;
        end
        return r;
    endfunction

    task automatic log_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        failures++;
    endtask

    task automatic restart_tensor();
        at_outer  = 0;
        at_middle = 0;
        at_inner  = 0;
        next_pos  = '0;
    endtask

    // Accumulate one element and queue the finished sum it may complete
    task automatic predict_sum(input logic signed [ELEM_W-1:0] elem);
        int unsigned             so, sm, si, red, red_n, pos, addr;
        logic [AXIS_W-1:0]       ax;
        logic signed [ACC_W-1:0] acc;
        logic signed [ACC_W-1:0] ext;
        logic                    last;
        sum_rec_t                rec;
        so  = dim_of(reg_outer);
        sm  = dim_of(reg_middle);
        si  = dim_of(reg_inner);
        ax  = (reg_axis > AXIS_INNER) ? AXIS_INNER : reg_axis;
        ext = elem;
        case (ax)
            AXIS_OUTER: begin
                pos = at_middle * si + at_inner;
                red = at_outer;
                red_n = so;
            end
            AXIS_MIDDLE: begin
                pos = at_outer * si + at_inner;
                red = at_middle;
                red_n = sm;
            end
            default: begin
                pos = at_outer * sm + at_middle;
                red = at_inner;
                red_n = si;
            end
        endcase
        addr = pos % MAX_PARTIALS;
        if (red == 0) begin
            acc = ext;
        end else begin
            acc = part_mem[addr] + ext;
        end
        part_mem[addr] = acc;
        last = (at_outer + 1 == so) && (at_middle + 1 == sm) && (at_inner + 1 == si);

        if (red + 1 == red_n) begin
            if (acc > ACC_SAT_HI) begin
                rec.sum = SUM_MAX;
            end else if (acc < ACC_SAT_LO) begin
                rec.sum = SUM_MIN;
            end else begin
                rec.sum = acc[ELEM_W-1:0];
            end
            rec.position = next_pos;
            rec.done     = last;
            sums_due.insert(sums_due.size(), rec);
            next_pos = next_pos + 1'b1;
        end

        if (last) begin
            restart_tensor();
        end else begin
            at_inner++;
            if (at_inner >= si) begin
                at_inner = 0;
                at_middle++;
                if (at_middle >= sm) begin
                    at_middle = 0;
                    at_outer++;
                    if (at_outer >= so) begin
                        at_outer = 0;
                    end
                end
            end
        end
    endtask

    always @(posedge aclk) begin
        sum_rec_t due;
        if (!aresetn) begin
            for (int n = 0; n < MAX_PARTIALS; n++) begin
                part_mem[n] = '0;
            end
            reg_outer  = DIM_W'(1);
            reg_middle = DIM_W'(1);
            reg_inner  = DIM_W'(1);
            reg_axis   = AXIS_OUTER;
            restart_tensor();
            sums_due.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (sums_due.size() == 0) begin
                    log_mismatch($sformatf("sum %0d at position %0d with nothing due",
                                           m_sum_value, m_out_position));
                end else begin
                    due = sums_due.pop_front();
                    if (m_sum_value !== due.sum) begin
                        log_mismatch($sformatf("position %0d: sum %0d, want %0d",
                                               due.position, m_sum_value, due.sum));
                    end
                    if (m_out_position !== due.position) begin
                        log_mismatch($sformatf("out_position %0d, want %0d",
                                               m_out_position, due.position));
                    end
                    if (m_tensor_done !== due.done) begin
                        log_mismatch($sformatf("position %0d: tensor_done %b, want %b",
                                               due.position, m_tensor_done, due.done));
                    end
                end
            end
            if (cfg_wr_en) begin
                case (cfg_index_t'(cfg_wr_index))
                    REG_SIZE_OUTER:  reg_outer  = cfg_wr_data;
                    REG_SIZE_MIDDLE: reg_middle = cfg_wr_data;
                    REG_SIZE_INNER:  reg_inner  = cfg_wr_data;
                    REG_REDUCE_AXIS: reg_axis   = cfg_wr_data[AXIS_W-1:0];
                    default: ;
                endcase
                restart_tensor();
            end
            if (s_valid && s_ready) begin
                predict_sum(s_element_value);
            end
        end
        pending <= sums_due.size();
    end

endmodule

@@ verif/tb.sv @@
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tars_pkg::*;

    // Axis code past the last dimension; the block folds it onto the inner axis
    localparam logic [AXIS_W-1:0] AXIS_OUT_OF_RANGE = 2'd3;
    // Cycles to let the pipeline empty after the last sum is due
    localparam int PIPE_SLACK  = 4;
    // Hard stop, far above the slowest legal run
    localparam int CYCLE_LIMIT = 400000;
    localparam int RAND_ITEMS  = 1100;

    logic                    aclk;
    logic                    aresetn;
    logic                    cfg_wr_en;
    logic [CFG_IDX_W-1:0]    cfg_wr_index;
    logic [DIM_W-1:0]        cfg_wr_data;
    logic                    s_valid;
    logic                    s_ready;
    logic signed [ELEM_W-1:0] s_element_value;
    logic                    m_valid;
    logic                    m_ready;
    logic signed [ELEM_W-1:0] m_sum_value;
    logic [POS_W-1:0]        m_out_position;
    logic                    m_tensor_done;

    int          failures;
    int          pending;
    int          send_idle_pct;
    int          recv_stall_pct;
    int unsigned cycle_count;

    tensor_axis_reduce_sum dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_index    (cfg_wr_index),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_element_value (s_element_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_sum_value     (m_sum_value),
        .m_out_position  (m_out_position),
        .m_tensor_done   (m_tensor_done)
    );

    reduce_sum_checker checker_i (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_index    (cfg_wr_index),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_element_value (s_element_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_sum_value     (m_sum_value),
        .m_out_position  (m_out_position),
        .m_tensor_done   (m_tensor_done),
        .failures        (failures),
        .pending         (pending)
    );

    // 12 ns clock, starting low
    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    // Stall the sum stream at the rate of the current phase
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Watchdog: stop a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Effective dimension, for working out how many items make a tensor
    function automatic int unsigned dim_of(input logic [DIM_W-1:0] s);
        int unsigned r;
        r = s;
        if (r == 0) begin
            r = 1;
        end else if (r > DIM_MAX) begin
            r = DIM_MAX;
        end
        return r;
    endfunction

    // Draw an element, leaning on the extremes so that sums saturate often
    function automatic logic [ELEM_W-1:0] pick_element();
        logic [ELEM_W-1:0] v;
        case ($urandom_range(0, 9))
            0: v = SUM_MAX;
            1: v = SUM_MIN;
            2: v = '0;
            3: v = ELEM_W'($urandom_range(0, 511)) - ELEM_W'(256);
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // Draw a size register value: mostly small, sometimes zero or oversize
    function automatic logic [DIM_W-1:0] pick_dim();
        logic [DIM_W-1:0] d;
        case ($urandom_range(0, 19))
            0: d = '0;
            1: d = $urandom_range(0, 1) ? DIM_W'(DIM_MAX)
                                        : DIM_W'($urandom_range(DIM_MAX + 1, 8191));
            2: d = DIM_W'($urandom_range(7, 16));
            default: d = DIM_W'($urandom_range(1, 6));
        endcase
        return d;
    endfunction

    // Present one item at the falling edge, hold it until accepted
    task automatic send_element(input logic [ELEM_W-1:0] v);
        @(negedge aclk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid         <= 1'b1;
        s_element_value <= v;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
    endtask

    // Drop valid and hold off until every due sum is out and the pipe is empty
    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending != 0) begin
            @(posedge aclk);
        end
        repeat (PIPE_SLACK) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [DIM_W-1:0] data);
        @(negedge aclk);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= data;
        @(posedge aclk);
    endtask

    // Send n items of a tensor; reprogram the shape first unless told to
    // continue with the current one. Optionally pause halfway until drained.
    task automatic run_tensor(input logic [DIM_W-1:0] so, input logic [DIM_W-1:0] sm,
                              input logic [DIM_W-1:0] si, input logic [DIM_W-1:0] axis_data,
                              input bit reprogram, input int n, input bit pause_mid,
                              input bit use_fixed, input logic [ELEM_W-1:0] fixed_value);
        if (reprogram) begin
            wait_drained();
            write_reg(REG_SIZE_OUTER, so);
            write_reg(REG_SIZE_MIDDLE, sm);
            write_reg(REG_SIZE_INNER, si);
            write_reg(REG_REDUCE_AXIS, axis_data);
            @(negedge aclk);
            cfg_wr_en <= 1'b0;
        end
        for (int e = 0; e < n; e++) begin
            if (pause_mid && e == n / 2) begin
                wait_drained();
            end
            send_element(use_fixed ? fixed_value : pick_element());
        end
    endtask

    initial begin
        logic [DIM_W-1:0] so, sm, si, ad;
        int unsigned      len;
        int               n, roll, rand_items;
        bit               reuse;

        aresetn         = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_wr_index    = '0;
        cfg_wr_data     = '0;
        s_valid         = 1'b0;
        s_element_value = '0;
        send_idle_pct   = 8;
        recv_stall_pct  = 60;
        rand_items      = 0;

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: reset shape is 1x1x1, so each item is its own finished sum
        send_element(SUM_MAX);
        send_element(SUM_MIN);
        // 1-D sums that pin at both rails
        run_tensor(4, 1, 1, DIM_W'(AXIS_OUTER), 1'b1, 4, 1'b0, 1'b1, SUM_MAX);
        run_tensor(4, 1, 1, DIM_W'(AXIS_OUTER), 1'b1, 4, 1'b0, 1'b1, SUM_MIN);
        // 2-D along the middle axis
        run_tensor(2, 2, 1, DIM_W'(AXIS_MIDDLE), 1'b1, 4, 1'b0, 1'b0, '0);
        // Zero sizes read as one; axis code three folds onto the inner axis
        run_tensor('0, '0, 3, {{(DIM_W - AXIS_W){1'b1}}, AXIS_OUT_OF_RANGE},
                   1'b1, 3, 1'b0, 1'b0, '0);
        // Full 3-D cube along the outer axis
        run_tensor(2, 2, 2, DIM_W'(AXIS_OUTER), 1'b1, 8, 1'b0, 1'b0, '0);
        // Oversize outer dimension with reduced size one; cut short, the
        // next write restarts the tensor
        run_tensor({DIM_W{1'b1}}, 1, 1, DIM_W'(AXIS_INNER), 1'b1, 3, 1'b0, 1'b0, '0);

        // Random shapes: mostly whole tensors, some cut short, some continued
        // without a rewrite, a few paused mid-stream until drained
        so = 1;
        sm = 1;
        si = 1;
        ad = '0;
        while (rand_items < RAND_ITEMS) begin
            if (rand_items < RAND_ITEMS / 3) begin
                send_idle_pct  = 8;
                recv_stall_pct = 60;
            end else if (rand_items < 2 * RAND_ITEMS / 3) begin
                send_idle_pct  = 60;
                recv_stall_pct = 8;
            end else begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            reuse = ($urandom_range(0, 4) == 0);
            if (!reuse) begin
                so = pick_dim();
                sm = pick_dim();
                si = pick_dim();
                ad = {(DIM_W - AXIS_W)'($urandom_range(0, 2047)),
                      AXIS_W'($urandom_range(0, 3))};
            end
            len  = dim_of(so) * dim_of(sm) * dim_of(si);
            roll = $urandom_range(0, 99);
            if (len > 300) begin
                n = $urandom_range(1, 40);
            end else if (roll < 12) begin
                n = $urandom_range(1, len);
            end else begin
                n = len;
            end
            run_tensor(so, sm, si, ad, !reuse, n, (roll >= 12 && roll < 20), 1'b0, '0);
            rand_items += n;
        end

        // Drain and let any stray sum show up before the verdict
        wait_drained();
        repeat (PIPE_SLACK) @(posedge aclk);
        if (failures == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
